[hw/rtl/command_config_frame_parser_unit_defines.svh]
// Assertion macros shared by the frame parser checker.
`ifndef COMMAND_CONFIG_FRAME_PARSER_UNIT_DEFINES_SVH
`define COMMAND_CONFIG_FRAME_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFPU_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frame parser check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFPU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frame parser check failed");

`endif

[hw/rtl/cfpu_pkg.sv]
// Package with shared types, codes and slot limits of the frame parser.
`default_nettype none

package cfpu_pkg;

	// Frame byte positions.
	localparam logic [2:0] POS_IDLE  = 3'd0;
	localparam logic [2:0] POS_B1    = 3'd1;
	localparam logic [2:0] POS_B2    = 3'd2;
	localparam logic [2:0] POS_B3    = 3'd3;
	localparam logic [2:0] POS_CHECK = 3'd4;

	// Configuration register indexes.
	localparam logic CFG_COMMAND_START  = 1'b0;
	localparam logic CFG_SETTINGS_START = 1'b1;

	// Reset values of the start byte registers.
	localparam logic [7:0] COMMAND_START_RESET  = 8'd170;
	localparam logic [7:0] SETTINGS_START_RESET = 8'd204;

	// Frame kind codes.
	localparam logic KIND_COMMAND  = 1'b0;
	localparam logic KIND_SETTINGS = 1'b1;

	localparam int SLOT_COUNT = 9;
	localparam int PAYLOAD_COUNT = 3;
	localparam logic [3:0] UNKNOWN_SLOT = 4'd9;
	localparam logic [15:0] DRIVE_RESET = 16'h7FFF;
	localparam logic [15:0] SLOT_RESET = 16'hFFFF;

	// One result item.
	typedef struct packed {
		logic               frame_done;
		logic               frame_good;
		logic               frame_kind;
		logic signed [15:0] drive_value;
		logic               drive_updated;
		logic [3:0]         slot_index;
		logic signed [15:0] slot_value;
		logic               slot_accepted;
	} result_t;

	// Lower inclusive limit of a slot, in raw units.
	function automatic logic signed [15:0] slot_low(input logic [3:0] id);
		logic signed [15:0] lim;
		unique case (id)
			4'd1: lim = 16'sd1600;
			4'd3: lim = 16'sd1000;
			4'd5: lim = 16'sd20;
			4'd6: lim = 16'sd1000;
			4'd7: lim = 16'sd100;
			default: lim = 16'sd10;
		endcase
		return lim;
	endfunction

	// Upper inclusive limit of a slot, in raw units.
	function automatic logic signed [15:0] slot_high(input logic [3:0] id);
		logic signed [15:0] lim;
		unique case (id)
			4'd1: lim = 16'sd5000;
			4'd3: lim = 16'sd10000;
			4'd4: lim = 16'sd200;
			4'd6: lim = 16'sd8000;
			4'd7: lim = 16'sd2000;
			default: lim = 16'sd150;
		endcase
		return lim;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/command_config_frame_parser_unit.sv]
// Top level of the command and configuration frame parser.
//
// The block takes one received byte per transfer on the input channel
// (in_valid, in_stall, rx_byte) and returns exactly one result per byte on the
// output channel (out_valid, out_stall and the result fields). It hunts for a
// command or settings start byte, collects a five-byte frame and checks the
// XOR checksum in the last byte; good command frames update drive_value and
// good, in-range settings frames are stored in the slot table.
// A byte sits in an input register, then the parse logic writes its result
// into the output register, from which it is offered on the output channel.
// One byte per cycle is sustained while the receiver does not stall. The path
// is one input register, the compare and XOR logic, and one output register.
// When the receiver stalls, the result is held and the input register still
// takes one more byte; the input stall rises only once both are full.
// Reset clears the frame state, sets drive_value to 0x7FFF, marks all slots
// unconfigured and loads the start bytes 170 (command) and 204 (settings).
// The start bytes may be rewritten over the cfg port while the block is idle.
`default_nettype none

module command_config_frame_parser_unit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_write,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic                    frame_done,
	output logic                    frame_good,
	output logic                    frame_kind,
	output logic signed [15:0]      drive_value,
	output logic                    drive_updated,
	output logic [3:0]              slot_index,
	output logic signed [15:0]      slot_value,
	output logic                    slot_accepted
);

	logic [7:0]        command_start_byte_q;
	logic [7:0]        settings_start_byte_q;
	logic              valid_s1;
	logic [7:0]        rx_byte_s1;
	logic              valid_s2;
	cfpu_pkg::result_t res_s2;
	cfpu_pkg::result_t res_next;
	logic              advance;

	// Start byte registers, written through the cfg port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_start_byte_q  <= cfpu_pkg::COMMAND_START_RESET;
			settings_start_byte_q <= cfpu_pkg::SETTINGS_START_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cfpu_pkg::CFG_COMMAND_START:  command_start_byte_q  <= cfg_data;
				cfpu_pkg::CFG_SETTINGS_START: settings_start_byte_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The input byte moves on whenever the result register is free or drains.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	cfpu_frame_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.rx_byte        (rx_byte_s1),
		.command_start  (command_start_byte_q),
		.settings_start (settings_start_byte_q),
		.res            (res_next)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid     = valid_s2;
	assign frame_done    = res_s2.frame_done;
	assign frame_good    = res_s2.frame_good;
	assign frame_kind    = res_s2.frame_kind;
	assign drive_value   = res_s2.drive_value;
	assign drive_updated = res_s2.drive_updated;
	assign slot_index    = res_s2.slot_index;
	assign slot_value    = res_s2.slot_value;
	assign slot_accepted = res_s2.slot_accepted;

endmodule

`default_nettype wire

[hw/rtl/cfpu_slot_check.sv]
// Range check of a configuration value against its slot's fixed limits.
`default_nettype none

module cfpu_slot_check (
	input  wire logic [7:0]         slot_id,
	input  wire logic signed [15:0] value,
	output logic                    known,
	output logic [3:0]              slot_index,
	output logic                    in_range
);

	logic signed [15:0] low;
	logic signed [15:0] high;

	// Ids beyond the table map to the unknown slot code.
	assign known      = (slot_id < 8'(cfpu_pkg::SLOT_COUNT));
	assign slot_index = known ? slot_id[3:0] : cfpu_pkg::UNKNOWN_SLOT;

	// Limits are looked up by id and compared as signed values.
	assign low      = cfpu_pkg::slot_low(slot_id[3:0]);
	assign high     = cfpu_pkg::slot_high(slot_id[3:0]);
	assign in_range = known && (value >= low) && (value <= high);

endmodule

`default_nettype wire

[hw/rtl/cfpu_frame_core.sv]
// Frame state, payload capture, checksum and stores of the frame parser.
`default_nettype none

module cfpu_frame_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                advance,
	input  wire logic [7:0]          rx_byte,
	input  wire logic [7:0]          command_start,
	input  wire logic [7:0]          settings_start,
	output cfpu_pkg::result_t        res
);

	logic [2:0]  pos_q;
	logic [2:0]  pos_d;
	logic        settings_q;
	logic        settings_d;
	logic [7:0]  payload_q [cfpu_pkg::PAYLOAD_COUNT];
	logic [2:0]  pos_minus_one;
	logic [1:0]  payload_idx;
	logic        payload_we;
	logic [15:0] drive_q;
	logic [15:0] drive_d;
	logic [15:0] setting_table_q [cfpu_pkg::SLOT_COUNT];
	logic        table_we;
	logic [7:0]  checksum;
	logic        sum_good;
	logic [15:0] cfg_raw;
	logic        slot_known;
	logic [3:0]  slot_idx;
	logic        slot_in_range;

	assign pos_minus_one = pos_q - 3'd1;
	assign payload_idx   = pos_minus_one[1:0];
	assign checksum      = payload_q[0] ^ payload_q[1] ^ payload_q[2];
	assign sum_good      = (checksum == rx_byte);
	assign cfg_raw       = {payload_q[2], payload_q[1]};

	cfpu_slot_check u_slot_check (
		.slot_id    (payload_q[0]),
		.value      (cfg_raw),
		.known      (slot_known),
		.slot_index (slot_idx),
		.in_range   (slot_in_range)
	);

	// Next state and result for the byte at the input register.
	always_comb begin
		pos_d      = pos_q;
		settings_d = settings_q;
		drive_d    = drive_q;
		payload_we = 1'b0;
		table_we   = 1'b0;
		res        = '0;
		unique case (pos_q) inside
			cfpu_pkg::POS_IDLE: begin
				if (rx_byte == command_start) begin
					settings_d = cfpu_pkg::KIND_COMMAND;
					pos_d      = cfpu_pkg::POS_B1;
				end else if (rx_byte == settings_start) begin
					settings_d = cfpu_pkg::KIND_SETTINGS;
					pos_d      = cfpu_pkg::POS_B1;
				end
			end
			cfpu_pkg::POS_B1, cfpu_pkg::POS_B2, cfpu_pkg::POS_B3: begin
				payload_we = 1'b1;
				pos_d      = pos_q + 3'd1;
			end
			cfpu_pkg::POS_CHECK: begin
				res.frame_done = 1'b1;
				res.frame_good = sum_good;
				res.frame_kind = settings_q;
				if (settings_q == cfpu_pkg::KIND_COMMAND) begin
					if (sum_good) begin
						drive_d           = {payload_q[1], payload_q[0]};
						res.drive_updated = 1'b1;
					end
				end else begin
					res.slot_index    = slot_idx;
					res.slot_value    = cfg_raw;
					table_we          = sum_good && slot_known && slot_in_range;
					res.slot_accepted = table_we;
				end
				pos_d      = cfpu_pkg::POS_IDLE;
				settings_d = cfpu_pkg::KIND_COMMAND;
			end
			default: begin
				pos_d      = cfpu_pkg::POS_IDLE;
				settings_d = cfpu_pkg::KIND_COMMAND;
			end
		endcase
		res.drive_value = drive_d;
	end

	// Control state and stores advance once per transfer into the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= cfpu_pkg::POS_IDLE;
			settings_q <= cfpu_pkg::KIND_COMMAND;
			drive_q    <= cfpu_pkg::DRIVE_RESET;
			for (int i = 0; i < cfpu_pkg::SLOT_COUNT; i++) begin
				setting_table_q[i] <= cfpu_pkg::SLOT_RESET;
			end
		end else if (advance) begin
			pos_q      <= pos_d;
			settings_q <= settings_d;
			drive_q    <= drive_d;
			if (table_we) begin
				setting_table_q[slot_idx] <= cfg_raw;
			end
		end
	end

	// Payload bytes need no reset; each is written before the checksum byte.
	always_ff @(posedge clk) begin
		if (advance && payload_we) begin
			payload_q[payload_idx] <= rx_byte;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/cfpu_checker.sv]
// Port-level checker of the frame parser and its bind to the top level.
`default_nettype none

`include "command_config_frame_parser_unit_defines.svh"

module cfpu_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire logic               frame_done,
	input wire logic               frame_good,
	input wire logic               frame_kind,
	input wire logic signed [15:0] drive_value,
	input wire logic               drive_updated,
	input wire logic [3:0]         slot_index,
	input wire logic               slot_accepted
);

	logic slot_known;

	// The reported slot is one of the table entries.
	assign slot_known = (slot_index != cfpu_pkg::UNKNOWN_SLOT);

	// A stalled result stays offered and its drive value unchanged.
	`CFPU_ASSERT_NEXT(a_stall_hold, out_valid && out_stall, out_valid && $stable(drive_value))

	// A drive update only comes from a good command frame.
	`CFPU_ASSERT_NOW(a_update_src, out_valid && drive_updated, frame_done && frame_good && !frame_kind)

	// A stored setting needs a good settings frame with a known slot.
	`CFPU_ASSERT_NOW(a_store_src, out_valid && slot_accepted, frame_good && frame_kind && slot_known)

	// Bytes that complete no frame report nothing.
	`CFPU_ASSERT_NOW(a_idle_quiet, out_valid && !frame_done, !frame_good && !drive_updated && !slot_accepted)

endmodule

bind command_config_frame_parser_unit cfpu_checker u_cfpu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.frame_done    (frame_done),
	.frame_good    (frame_good),
	.frame_kind    (frame_kind),
	.drive_value   (drive_value),
	.drive_updated (drive_updated),
	.slot_index    (slot_index),
	.slot_accepted (slot_accepted)
);

`default_nettype wire

[tb/sv/command_config_frame_parser_unit_checker.sv]
`timescale 1ns / 1ps
// Checker that predicts and compares every result of the frame parser.
module command_config_frame_parser_unit_checker
	import cfpu_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_write,
	input  logic               cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic               frame_done,
	input  logic               frame_good,
	input  logic               frame_kind,
	input  logic signed [15:0] drive_value,
	input  logic               drive_updated,
	input  logic [3:0]         slot_index,
	input  logic signed [15:0] slot_value,
	input  logic               slot_accepted,
	output int                 failures,
	output int                 outstanding
);

	// Shadow copy of the parser state and the start byte registers.
	logic [2:0]  frame_pos;
	logic        open_kind;
	logic [7:0]  payload [PAYLOAD_COUNT];
	logic [15:0] drive_shadow;
	logic [15:0] slot_shadow [SLOT_COUNT];
	logic [7:0]  command_head;
	logic [7:0]  settings_head;

	// Results predicted for accepted bytes, oldest first.
	result_t pending_results [$];

	// True when a value lies inside the inclusive window of its slot.
	function automatic logic within_limits(input logic [3:0] slot, input logic signed [15:0] v);
		int lo;
		int hi;
		case (slot)
			4'd1: begin lo = 1600; hi = 5000; end
			4'd3: begin lo = 1000; hi = 10000; end
			4'd4: begin lo = 10; hi = 200; end
			4'd5: begin lo = 20; hi = 150; end
			4'd6: begin lo = 1000; hi = 8000; end
			4'd7: begin lo = 100; hi = 2000; end
			default: begin lo = 10; hi = 150; end
		endcase
		return (v >= lo) && (v <= hi);
	endfunction

	// Advances the shadow parser by one byte and returns the result it causes.
	function automatic result_t parse_byte(input logic [7:0] b);
		result_t r;
		logic [7:0] sum;
		logic signed [15:0] word;
		r = '0;
		if (frame_pos == POS_IDLE) begin
			// A command start wins when both start bytes are equal.
			if (b == command_head) begin
				open_kind = KIND_COMMAND;
				frame_pos = POS_B1;
			end else if (b == settings_head) begin
				open_kind = KIND_SETTINGS;
				frame_pos = POS_B1;
			end
		end else if (frame_pos != POS_CHECK) begin
			payload[frame_pos - 3'd1] = b;
			frame_pos = frame_pos + 3'd1;
		end else begin
			sum = payload[0] ^ payload[1] ^ payload[2];
			r.frame_done = 1'b1;
			r.frame_good = (sum == b);
			r.frame_kind = open_kind;
			if (open_kind == KIND_COMMAND) begin
				if (r.frame_good) begin
					drive_shadow = {payload[1], payload[0]};
					r.drive_updated = 1'b1;
				end
			end else begin
				// Settings frames report the slot and value even when dropped.
				word = {payload[2], payload[1]};
				r.slot_value = word;
				r.slot_index = (payload[0] < SLOT_COUNT) ? payload[0][3:0] : UNKNOWN_SLOT;
				if (r.frame_good && payload[0] < SLOT_COUNT &&
						within_limits(payload[0][3:0], word)) begin
					slot_shadow[payload[0]] = word;
					r.slot_accepted = 1'b1;
				end
			end
			frame_pos = POS_IDLE;
			open_kind = KIND_COMMAND;
		end
		r.drive_value = drive_shadow;
		return r;
	endfunction

	// Reports one field that differs from its prediction.
	task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			failures = failures + 1;
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// Watch both channels and the register port at every rising edge.
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			frame_pos = POS_IDLE;
			open_kind = KIND_COMMAND;
			drive_shadow = DRIVE_RESET;
			for (int i = 0; i < SLOT_COUNT; i++)
				slot_shadow[i] = SLOT_RESET;
			command_head = COMMAND_START_RESET;
			settings_head = SETTINGS_START_RESET;
			pending_results.delete();
			failures = 0;
			outstanding <= 0;
		end else begin
			// Result transfer: compare against the oldest prediction.
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					failures = failures + 1;
					$display("%0t: result transfer with no prediction waiting", $time);
				end else begin
					want = pending_results.pop_front();
					check_field("frame_done", want.frame_done, frame_done);
					check_field("frame_good", want.frame_good, frame_good);
					check_field("frame_kind", want.frame_kind, frame_kind);
					check_field("drive_value", want.drive_value, drive_value);
					check_field("drive_updated", want.drive_updated, drive_updated);
					check_field("slot_index", want.slot_index, slot_index);
					check_field("slot_value", want.slot_value, slot_value);
					check_field("slot_accepted", want.slot_accepted, slot_accepted);
				end
			end
			// Byte transfer: predict its result.
			if (in_valid && !in_stall)
				pending_results.push_back(parse_byte(rx_byte));
			// Register writes take effect for the bytes that follow.
			if (cfg_write) begin
				if (cfg_index == CFG_COMMAND_START)
					command_head = cfg_data;
				else
					settings_head = cfg_data;
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

[tb/sv/command_config_frame_parser_unit_tb.sv]
`timescale 1ns / 1ps
// Top of the frame parser testbench: clock, reset, stimulus and verdict.
module command_config_frame_parser_unit_tb;
	import cfpu_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	logic               clk;
	logic               arst_n;
	logic               cfg_write;
	logic               cfg_index;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_stall;
	logic               frame_done;
	logic               frame_good;
	logic               frame_kind;
	logic signed [15:0] drive_value;
	logic               drive_updated;
	logic [3:0]         slot_index;
	logic signed [15:0] slot_value;
	logic               slot_accepted;
	int                 failures;
	int                 outstanding;

	// Start bytes currently loaded in the block.
	logic [7:0] cmd_start = COMMAND_START_RESET;
	logic [7:0] set_start = SETTINGS_START_RESET;

	int send_calm = 0;
	int stall_calm = 0;
	int cycles = 0;

	command_config_frame_parser_unit dut (.*);

	command_config_frame_parser_unit_checker checker_0 (.*);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Run-away guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Draws a wait in cycles, with occasional stretches of no waiting at all.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		if ($urandom_range(0, 31) == 0) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 16) : 0;
	endfunction

	// Receiver: stalls a random number of cycles before each result transfer.
	initial begin : receiver
		int hold;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			hold = draw_wait(stall_calm);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// Sends one byte after a random gap and returns at the edge of its transfer.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = draw_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
	endtask

	// Sends a five-byte frame; a nonzero spoil mask corrupts the checksum.
	task automatic send_five(input logic [7:0] head, input logic [7:0] b1, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] spoil);
		send_byte(head);
		send_byte(b1);
		send_byte(b2);
		send_byte(b3);
		send_byte(b1 ^ b2 ^ b3 ^ spoil);
	endtask

	// Holds off new bytes until every predicted result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// Writes one start byte register once the block has gone quiet.
	task automatic write_reg(input logic idx, input logic [7:0] val);
		drain_results();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_COMMAND_START)
			cmd_start = val;
		else
			set_start = val;
	endtask

	// Random five-byte frame, sometimes with a bad checksum; settings values mostly near the slot limits.
	task automatic send_frame(input logic as_settings);
		logic [7:0] b1;
		logic [7:0] spoil;
		logic [15:0] word;
		logic [3:0] id;
		int lo;
		int hi;
		spoil = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
		if (as_settings) begin
			id = 4'($urandom_range(0, 9));
			b1 = (id < SLOT_COUNT) ? {4'h0, id} : 8'($urandom_range(9, 255));
			lo = slot_low(id);
			hi = slot_high(id);
			case ($urandom_range(0, 5))
				0: word = 16'(lo - 1);
				1: word = 16'(lo);
				2: word = 16'(hi);
				3: word = 16'(hi + 1);
				4: word = 16'(lo + $urandom_range(0, hi - lo));
				default: word = 16'($urandom_range(0, 65535));
			endcase
			send_five(set_start, b1, word[7:0], word[15:8], spoil);
		end else begin
			case ($urandom_range(0, 4))
				0: word = 16'h8000;
				1: word = 16'h7FFF;
				2: word = 16'h0000;
				default: word = 16'($urandom_range(0, 65535));
			endcase
			send_five(cmd_start, word[7:0], word[15:8], 8'($urandom_range(0, 255)), spoil);
		end
	endtask

	// Main stimulus.
	initial begin : stimulus
		int pick;
		logic [7:0] next_cmd;
		logic [7:0] next_set;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_COMMAND_START;
		cfg_data = 8'h00;
		in_valid = 1'b0;
		rx_byte = 8'h00;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle noise, command extremes, bad checksum, slot limits, unknown slot.
		send_byte(8'h00);
		send_byte(8'hFF);
		send_five(cmd_start, 8'h00, 8'h80, 8'hFF, 8'h00);
		send_five(cmd_start, 8'hFF, 8'h7F, 8'h00, 8'h01);
		send_five(set_start, 8'h08, 8'd150, 8'h00, 8'h00);
		send_five(set_start, 8'h00, 8'd9, 8'h00, 8'h00);
		send_five(set_start, 8'hFF, 8'hFF, 8'hFF, 8'h80);

		// Random phases under varying pairs of start bytes; the first and last use the reset pair.
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin next_cmd = 8'h00; next_set = 8'hFF; end
				2: begin next_cmd = 8'hFF; next_set = 8'h00; end
				3: begin next_cmd = 8'h5A; next_set = 8'h5A; end
				4: begin
					next_cmd = 8'($urandom_range(0, 255));
					next_set = 8'($urandom_range(0, 255));
				end
				default: begin next_cmd = COMMAND_START_RESET; next_set = SETTINGS_START_RESET; end
			endcase
			if (phase == 4) begin
				// Open a frame, then change the start bytes before it completes.
				send_byte(cmd_start);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(8'($urandom_range(0, 255)));
				write_reg(CFG_COMMAND_START, next_cmd);
				write_reg(CFG_SETTINGS_START, next_set);
				send_byte(8'($urandom_range(0, 255)));
				send_byte(8'($urandom_range(0, 255)));
			end else if (phase != 0) begin
				write_reg(CFG_COMMAND_START, next_cmd);
				write_reg(CFG_SETTINGS_START, next_set);
			end
			repeat (35) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					send_frame(pick >= 3);
				end else if (pick == 7) begin
					send_byte(8'($urandom_range(0, 255)));
				end else begin
					// Broken frame: a start byte and a short random tail.
					send_byte(($urandom_range(0, 1) == 0) ? cmd_start : set_start);
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
				end
			end
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
